FILE: design/stts_pkg.sv
// Package: request types and scan stage codes for the sleep type table scanner.
`timescale 1ns / 1ps

package stts_pkg;

  // Input request: one table byte with the end-of-table flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // Result request: one per table
  typedef struct packed {
    logic [2:0] sleep_type;
    logic       found;
    logic       sum_ok;
  } out_t;

  // Position in the soft-off object sequence
  typedef enum logic [3:0] {
    ST_SEEK   = 4'd0,
    ST_US1    = 4'd1,
    ST_S      = 4'd2,
    ST_FIVE   = 4'd3,
    ST_US2    = 4'd4,
    ST_PKG    = 4'd5,
    ST_LEAD   = 4'd6,
    ST_SKIP   = 4'd7,
    ST_COUNT  = 4'd8,
    ST_PREFIX = 4'd9,
    ST_VALUE  = 4'd10
  } stage_t;

  // Bytes of the sequence
  localparam logic [7:0] NAME_OP    = 8'h08;
  localparam logic [7:0] PKG_OP     = 8'h12;
  localparam logic [7:0] BYTE_PFX   = 8'h0A;
  localparam logic [7:0] CHR_US     = 8'h5F;
  localparam logic [7:0] CHR_S      = 8'h53;
  localparam logic [7:0] CHR_FIVE   = 8'h35;
  localparam logic [2:0] TYPE_MASK  = 3'h7;

endpackage

FILE: design/sleep_type_table_scanner_top.sv
// Top level: input register, scan engine and result register of the table scanner.
//
//   channel | direction | payload         | handshake
//   in_     | input     | stts_pkg::in_t  | in_valid / in_stall
//   out_    | output    | stts_pkg::out_t | out_valid / out_stall
//
// One byte per cycle unless out_stall holds a result; a byte goes input register ->
// scan engine -> result register, which raises out_valid for the final byte.
// Only the final byte of a table produces a result request.
// Synchronous active-low reset clears the scan state and both valid flags.
// A held result under out_stall stops a full input register, which raises in_stall.
`timescale 1ns / 1ps

module sleep_type_table_scanner_top #(
  parameter int HEADER_BYTES = 36
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  stts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output stts_pkg::out_t out_data
);

  logic           in_valid_r;
  stts_pkg::in_t  in_data_r;
  logic           out_valid_r;
  stts_pkg::out_t out_data_r;
  stts_pkg::out_t res;
  logic           advance;
  logic           step;

  // input register moves on unless a result is held against a stall
  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  stts_scan #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (in_data_r),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step && in_data_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_data_r.last_byte) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/stts_scan.sv
// Scan engine: running checksum, header skip and soft-off object match state.
`timescale 1ns / 1ps

module stts_scan #(
  parameter int HEADER_BYTES = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  stts_pkg::in_t item,
  output stts_pkg::out_t res
);

  localparam int HCW = $clog2(HEADER_BYTES + 1);

  logic [7:0]       sum_r, sum_nxt;
  logic [HCW-1:0]   hdr_cnt_r, hdr_cnt_nxt;
  stts_pkg::stage_t stage_r, stage_nxt;
  logic [1:0]       skip_r, skip_nxt;
  logic             done_r, done_nxt;
  logic [2:0]       held_r, held_nxt;
  logic [7:0]       b;
  stts_pkg::stage_t restart;

  assign b = item.data_byte;
  // a broken match restarts on a name opcode
  assign restart = (b == stts_pkg::NAME_OP) ? stts_pkg::ST_US1 : stts_pkg::ST_SEEK;

  // Next state for one byte
  always_comb begin
    sum_nxt     = sum_r + b;
    hdr_cnt_nxt = hdr_cnt_r;
    stage_nxt   = stage_r;
    skip_nxt    = skip_r;
    done_nxt    = done_r;
    held_nxt    = held_r;
    if (hdr_cnt_r < HCW'(HEADER_BYTES)) begin
      hdr_cnt_nxt = hdr_cnt_r + 1'b1;
    end else if (!done_r) begin
      case (stage_r)
        stts_pkg::ST_SEEK:  stage_nxt = restart;
        stts_pkg::ST_US1:   stage_nxt = (b == stts_pkg::CHR_US)   ? stts_pkg::ST_S    : restart;
        stts_pkg::ST_S:     stage_nxt = (b == stts_pkg::CHR_S)    ? stts_pkg::ST_FIVE : restart;
        stts_pkg::ST_FIVE:  stage_nxt = (b == stts_pkg::CHR_FIVE) ? stts_pkg::ST_US2  : restart;
        stts_pkg::ST_US2:   stage_nxt = (b == stts_pkg::CHR_US)   ? stts_pkg::ST_PKG  : restart;
        stts_pkg::ST_PKG:   stage_nxt = (b == stts_pkg::PKG_OP)   ? stts_pkg::ST_LEAD : restart;
        stts_pkg::ST_LEAD: begin
          // top two bits of the lead byte count extra length bytes
          skip_nxt  = b[7:6];
          stage_nxt = (b[7:6] != 2'd0) ? stts_pkg::ST_SKIP : stts_pkg::ST_COUNT;
        end
        stts_pkg::ST_SKIP: begin
          skip_nxt = skip_r - 2'd1;
          if (skip_r == 2'd1) begin
            stage_nxt = stts_pkg::ST_COUNT;
          end
        end
        stts_pkg::ST_COUNT: stage_nxt = stts_pkg::ST_PREFIX;
        stts_pkg::ST_PREFIX: begin
          if (b == stts_pkg::BYTE_PFX) begin
            stage_nxt = stts_pkg::ST_VALUE;
          end else begin
            held_nxt  = b[2:0] & stts_pkg::TYPE_MASK;
            done_nxt  = 1'b1;
            stage_nxt = stts_pkg::ST_SEEK;
          end
        end
        stts_pkg::ST_VALUE: begin
          held_nxt  = b[2:0] & stts_pkg::TYPE_MASK;
          done_nxt  = 1'b1;
          stage_nxt = stts_pkg::ST_SEEK;
        end
        default: stage_nxt = restart;
      endcase
    end
  end

  // Result for the final byte
  always_comb begin
    res.sum_ok     = (sum_nxt == 8'd0);
    res.found      = done_nxt;
    res.sleep_type = (res.sum_ok && done_nxt) ? held_nxt : 3'd0;
  end

  // State registers; the final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      sum_r     <= '0;
      hdr_cnt_r <= '0;
      stage_r   <= stts_pkg::ST_SEEK;
      skip_r    <= '0;
      done_r    <= 1'b0;
      held_r    <= '0;
    end else if (step) begin
      sum_r     <= sum_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      stage_r   <= stage_nxt;
      skip_r    <= skip_nxt;
      done_r    <= done_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

FILE: design/stts_checker.sv
// Port-level assertions for the table scanner, bound to the top level.
`timescale 1ns / 1ps

module stts_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input stts_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input stts_pkg::out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a stalled input request stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input request changed while stalled");

  // a nonzero sleep type needs a match and a good checksum
  a_type_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.sleep_type != 3'd0) |-> out_data.found && out_data.sum_ok)
    else $error("sleep type reported without match or checksum");

  // input backpressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sleep_type_table_scanner_top stts_checker u_stts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
